>>> rtl/core/cwsm_pkg.sv
`timescale 1ns / 1ps
package cwsm_pkg;

  localparam int ANGLE_BITS_DEF = 13;
  localparam int QUEUE_DEPTH    = 4;
  localparam int SPEED_LIMIT    = 8888;

  localparam int CMD_W   = 12;
  localparam int TURN_W  = 14;
  localparam int GAIN_W  = 12;
  localparam int POWER_W = 16;
  localparam int SPIN_W  = 13;
  localparam int WHEEL_W = 15;
  localparam int FOLD_W  = 17;
  localparam int MIX_W   = 15;
  localparam int FPROD_W = 28;
  localparam int VEC_W   = 24;
  localparam int TRIG_W  = 17;
  localparam int COMB_W  = 18;
  localparam int PROD_W  = 42;
  localparam int SUM_W   = 44;
  localparam int FRAC_SH = 23;
  localparam int FOLLOW_SH = 15;
  localparam int QUOT_W  = SUM_W - FRAC_SH;

  localparam logic [FOLD_W-1:0]  FOLD_ONE    = 17'h10000;
  localparam logic [15:0]        QUARTER_ONE = 16'd32767;

  localparam logic [POWER_W-1:0] PWR_LOW  = 16'd30;
  localparam logic [POWER_W-1:0] PWR_MID  = 16'd100;
  localparam logic [POWER_W-1:0] PWR_HIGH = 16'd300;
  localparam logic [SPIN_W-1:0]  SPIN_LOW  = 13'd1800;
  localparam logic [SPIN_W-1:0]  SPIN_MID  = 13'd6000;
  localparam logic [SPIN_W-1:0]  SPIN_HIGH = 13'd2000;
  localparam logic [5:0]         SPIN_PER_WATT = 6'd60;

  typedef enum logic [1:0] {
    MODE_FOLLOW    = 2'd0,
    MODE_SPIN      = 2'd1,
    MODE_TRANSLATE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FOLLOW,
    CLS_ROTATE
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [SPIN_W-1:0] spin;
    logic [CMD_W-1:0]  fwd;
    logic [CMD_W-1:0]  side;
    logic [TURN_W-1:0] turn;
    logic [GAIN_W-1:0] fgain;
    logic [GAIN_W-1:0] sgain;
    logic [FOLD_W-1:0] gs;
    logic              neg_s;
    logic [FOLD_W-1:0] gc;
    logic              neg_c;
  } cmd_t;

  function automatic logic [15:0] quarter_sine(input logic [5:0] idx);
    unique case (idx)
      6'd0:  quarter_sine = 16'd0;
      6'd1:  quarter_sine = 16'd1608;
      6'd2:  quarter_sine = 16'd3212;
      6'd3:  quarter_sine = 16'd4808;
      6'd4:  quarter_sine = 16'd6393;
      6'd5:  quarter_sine = 16'd7962;
      6'd6:  quarter_sine = 16'd9512;
      6'd7:  quarter_sine = 16'd11039;
      6'd8:  quarter_sine = 16'd12540;
      6'd9:  quarter_sine = 16'd14010;
      6'd10: quarter_sine = 16'd15447;
      6'd11: quarter_sine = 16'd16846;
      6'd12: quarter_sine = 16'd18205;
      6'd13: quarter_sine = 16'd19520;
      6'd14: quarter_sine = 16'd20788;
      6'd15: quarter_sine = 16'd22006;
      6'd16: quarter_sine = 16'd23170;
      6'd17: quarter_sine = 16'd24279;
      6'd18: quarter_sine = 16'd25330;
      6'd19: quarter_sine = 16'd26320;
      6'd20: quarter_sine = 16'd27246;
      6'd21: quarter_sine = 16'd28106;
      6'd22: quarter_sine = 16'd28899;
      6'd23: quarter_sine = 16'd29622;
      6'd24: quarter_sine = 16'd30274;
      6'd25: quarter_sine = 16'd30853;
      6'd26: quarter_sine = 16'd31357;
      6'd27: quarter_sine = 16'd31786;
      6'd28: quarter_sine = 16'd32138;
      6'd29: quarter_sine = 16'd32413;
      6'd30: quarter_sine = 16'd32610;
      6'd31: quarter_sine = 16'd32729;
      default: quarter_sine = QUARTER_ONE;
    endcase
  endfunction

endpackage

>>> rtl/core/cwsm_front.sv
`timescale 1ns / 1ps
module cwsm_front #(
  parameter int ANGLE_BITS = cwsm_pkg::ANGLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ANGLE_BITS-1:0]                  cfg_yaw_zero_offset,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             mode,
  input  logic signed [cwsm_pkg::CMD_W-1:0]      forward_cmd,
  input  logic signed [cwsm_pkg::CMD_W-1:0]      side_cmd,
  input  logic signed [cwsm_pkg::TURN_W-1:0]     turn_cmd,
  input  logic [cwsm_pkg::GAIN_W-1:0]            forward_gain,
  input  logic [cwsm_pkg::GAIN_W-1:0]            side_gain,
  input  logic [ANGLE_BITS-1:0]                  yaw_angle,
  input  logic [cwsm_pkg::POWER_W-1:0]           power_cap,
  output logic                                   push_valid,
  input  logic                                   push_full,
  output cwsm_pkg::cmd_t                         push_cmd
);
  import cwsm_pkg::*;

  localparam int QB = ANGLE_BITS - 2;

  logic [ANGLE_BITS-1:0] yaw_zero_offset;
  logic                  fv;
  cmd_t                  fcmd;
  cmd_t                  cmd_next;
  logic [ANGLE_BITS-1:0] heading;
  logic [ANGLE_BITS-1:0] heading_cos;
  logic [SPIN_W-1:0]     spin;
  logic                  accept;
  logic                  push;

  function automatic logic [FOLD_W-1:0] fold(input logic [ANGLE_BITS-1:0] p);
    logic [15:0] f;
    f = 16'(p[QB-1:0]) << (16 - QB);
    fold = p[QB] ? (FOLD_ONE - {1'b0, f}) : {1'b0, f};
  endfunction

  assign heading     = yaw_angle - yaw_zero_offset;
  assign heading_cos = heading + (ANGLE_BITS'(1) << QB);

  always_comb begin
    priority if (power_cap < PWR_LOW) begin
      spin = SPIN_LOW;
    end else if (power_cap > PWR_HIGH) begin
      spin = SPIN_HIGH;
    end else if (power_cap > PWR_MID) begin
      spin = SPIN_MID;
    end else begin
      spin = SPIN_W'(power_cap[6:0]) * SPIN_W'(SPIN_PER_WATT);
    end
  end

  always_comb begin
    cmd_next.fwd   = forward_cmd;
    cmd_next.side  = side_cmd;
    cmd_next.turn  = turn_cmd;
    cmd_next.fgain = forward_gain;
    cmd_next.sgain = side_gain;
    cmd_next.gs    = fold(heading);
    cmd_next.neg_s = heading[ANGLE_BITS-1];
    cmd_next.gc    = fold(heading_cos);
    cmd_next.neg_c = heading_cos[ANGLE_BITS-1];
    unique case (mode_t'(mode))
      MODE_FOLLOW: begin
        cmd_next.cls  = CLS_FOLLOW;
        cmd_next.spin = '0;
      end
      MODE_SPIN: begin
        cmd_next.cls  = CLS_ROTATE;
        cmd_next.spin = spin;
      end
      MODE_TRANSLATE: begin
        cmd_next.cls  = CLS_ROTATE;
        cmd_next.spin = '0;
      end
      default: begin
        cmd_next.cls  = CLS_ZERO;
        cmd_next.spin = '0;
      end
    endcase
  end

  assign in_stall   = fv && push_full;
  assign accept     = in_valid && !in_stall;
  assign push       = fv && !push_full;
  assign push_valid = fv;
  assign push_cmd   = fcmd;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv              <= 1'b0;
      yaw_zero_offset <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        yaw_zero_offset <= cfg_yaw_zero_offset;
      end
      if (accept) begin
        fv <= 1'b1;
      end else if (push) begin
        fv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fcmd <= cmd_next;
    end
  end

endmodule

>>> rtl/core/cwsm_queue.sv
`timescale 1ns / 1ps
module cwsm_queue #(
  parameter int DEPTH = cwsm_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           full,
  input  cwsm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cwsm_pkg::cmd_t pop_cmd
);
  import cwsm_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    full |-> (wr_ptr == rd_ptr))
    else $error("full queue with pointers apart");

endmodule

>>> rtl/core/cwsm_back.sv
`timescale 1ns / 1ps
module cwsm_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  cwsm_pkg::cmd_t                        pop_cmd,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_a_speed,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_b_speed,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_c_speed,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_d_speed
);
  import cwsm_pkg::*;

  localparam logic signed [QUOT_W-1:0] LIM = QUOT_W'(SPEED_LIMIT);

  // stage 1: sine/cosine, scaled vector, follow products
  logic                      v1;
  cls_t                      cls1;
  logic [SPIN_W-1:0]         spin1;
  logic signed [TRIG_W-1:0]  s1;
  logic signed [TRIG_W-1:0]  c1;
  logic signed [VEC_W-1:0]   x1;
  logic signed [VEC_W-1:0]   y1;
  logic signed [FPROD_W-1:0] fprod1 [4];
  // stage 2: rotation products
  logic                      v2;
  cls_t                      cls2;
  logic [SPIN_W-1:0]         spin2;
  logic signed [PROD_W-1:0]  pxm2;
  logic signed [PROD_W-1:0]  pxp2;
  logic signed [PROD_W-1:0]  pyp2;
  logic signed [PROD_W-1:0]  pym2;
  logic signed [FPROD_W-1:0] fprod2 [4];
  // stage 3: wheel sums at scale 2^23
  logic                      v3;
  cls_t                      cls3;
  logic signed [SUM_W-1:0]   sum3 [4];
  // output register
  logic                      vo;
  logic signed [WHEEL_W-1:0] wheel [4];

  logic                      r1;
  logic                      r2;
  logic                      r3;
  logic                      ro;
  logic signed [MIX_W-1:0]   fe;
  logic signed [MIX_W-1:0]   se;
  logic signed [MIX_W-1:0]   te;
  logic signed [MIX_W-1:0]   fsum [4];
  logic signed [COMB_W-1:0]  cms;
  logic signed [COMB_W-1:0]  cps;
  logic signed [SUM_W-1:0]   rs;

  function automatic logic signed [TRIG_W-1:0] sine_q15(input logic [FOLD_W-1:0] g,
                                                        input logic neg);
    logic [5:0]  idx;
    logic [10:0] frac;
    logic [15:0] base;
    logic [15:0] step;
    logic [21:0] prod;
    logic [15:0] mag;
    idx  = g[16:11];
    frac = g[10:0];
    base = quarter_sine(idx);
    step = quarter_sine(idx + 6'd1) - base;
    prod = 22'(step[10:0]) * 22'(frac);
    mag  = idx[5] ? QUARTER_ONE : base + 16'(prod[21:11]);
    sine_q15 = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [WHEEL_W-1:0] finish(input logic signed [SUM_W-1:0] v);
    logic signed [QUOT_W-1:0] q;
    q = $signed(v[SUM_W-1:FRAC_SH])
        + $signed({{(QUOT_W-1){1'b0}}, v[SUM_W-1] && (v[FRAC_SH-1:0] != '0)});
    if (q > LIM) begin
      finish = WHEEL_W'(LIM);
    end else if (q < -LIM) begin
      finish = WHEEL_W'(-LIM);
    end else begin
      finish = q[WHEEL_W-1:0];
    end
  endfunction

  assign ro        = !vo || !out_stall;
  assign r3        = !v3 || ro;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign pop_ready = r1;

  always_comb begin
    fe = MIX_W'($signed(pop_cmd.fwd));
    se = MIX_W'($signed(pop_cmd.side));
    te = MIX_W'($signed(pop_cmd.turn));
    fsum[0] =  fe + se + te;
    fsum[1] =  fe - se + te;
    fsum[2] = -fe + se + te;
    fsum[3] = -fe - se + te;
  end

  assign cms = COMB_W'(c1) - COMB_W'(s1);
  assign cps = COMB_W'(c1) + COMB_W'(s1);
  assign rs  = $signed({{(SUM_W-SPIN_W-FRAC_SH){1'b0}}, spin2, {FRAC_SH{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (r1) v1 <= pop_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (ro) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      cls1  <= pop_cmd.cls;
      spin1 <= pop_cmd.spin;
      s1    <= sine_q15(pop_cmd.gs, pop_cmd.neg_s);
      c1    <= sine_q15(pop_cmd.gc, pop_cmd.neg_c);
      x1    <= VEC_W'($signed(pop_cmd.side)) * VEC_W'($signed({1'b0, pop_cmd.sgain}));
      y1    <= VEC_W'($signed(pop_cmd.fwd)) * VEC_W'($signed({1'b0, pop_cmd.fgain}));
      for (int k = 0; k < 4; k++) begin
        fprod1[k] <= FPROD_W'(fsum[k]) * FPROD_W'($signed({1'b0, pop_cmd.fgain}));
      end
    end
    if (r2) begin
      cls2   <= cls1;
      spin2  <= spin1;
      pxm2   <= PROD_W'(x1) * PROD_W'(cms);
      pxp2   <= PROD_W'(x1) * PROD_W'(cps);
      pyp2   <= PROD_W'(y1) * PROD_W'(cps);
      pym2   <= PROD_W'(y1) * PROD_W'(cms);
      fprod2 <= fprod1;
    end
    if (r3) begin
      cls3 <= cls2;
      if (cls2 == CLS_FOLLOW) begin
        for (int k = 0; k < 4; k++) begin
          sum3[k] <= SUM_W'(fprod2[k]) <<< FOLLOW_SH;
        end
      end else begin
        sum3[0] <= rs + SUM_W'(pxm2) + SUM_W'(pyp2);
        sum3[1] <= rs - SUM_W'(pxp2) + SUM_W'(pym2);
        sum3[2] <= rs + SUM_W'(pxp2) - SUM_W'(pym2);
        sum3[3] <= rs - SUM_W'(pxm2) - SUM_W'(pyp2);
      end
    end
    if (ro) begin
      for (int k = 0; k < 4; k++) begin
        wheel[k] <= (cls3 == CLS_ZERO) ? '0 : finish(sum3[k]);
      end
    end
  end

  assign out_valid     = vo;
  assign wheel_a_speed = wheel[0];
  assign wheel_b_speed = wheel[1];
  assign wheel_c_speed = wheel[2];
  assign wheel_d_speed = wheel[3];

  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    vo |-> (wheel[0] <= WHEEL_W'(LIM) && wheel[0] >= -WHEEL_W'(LIM) &&
            wheel[1] <= WHEEL_W'(LIM) && wheel[1] >= -WHEEL_W'(LIM) &&
            wheel[2] <= WHEEL_W'(LIM) && wheel[2] >= -WHEEL_W'(LIM) &&
            wheel[3] <= WHEEL_W'(LIM) && wheel[3] >= -WHEEL_W'(LIM)))
    else $error("wheel speed beyond limit");

  a_hold_s3: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ro) |=> v3)
    else $error("stage 3 beat dropped while blocked");

  a_hold_s2: assert property (@(posedge clk) disable iff (rst)
    (v2 && !r3) |=> v2)
    else $error("stage 2 beat dropped while blocked");

endmodule

>>> rtl/core/chassis_wheel_speed_mixer_core.sv
`timescale 1ns / 1ps
// Path from an accepted input beat to out_valid: front register, queue, three arithmetic
//   stages, output register; out_stall holds the back end and delays the result.
// Throughput: one beat per cycle while out_stall is low, set by the pipelined back end.
// Reset (rst, synchronous): empties the front register, queue and pipeline, and clears
//   yaw_zero_offset to 0. No clearing pass; the block accepts beats right after reset.
module chassis_wheel_speed_mixer_core #(
  parameter int ANGLE_BITS  = cwsm_pkg::ANGLE_BITS_DEF,
  parameter int QUEUE_DEPTH = cwsm_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ANGLE_BITS-1:0]                cfg_yaw_zero_offset,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           mode,
  input  logic signed [cwsm_pkg::CMD_W-1:0]    forward_cmd,
  input  logic signed [cwsm_pkg::CMD_W-1:0]    side_cmd,
  input  logic signed [cwsm_pkg::TURN_W-1:0]   turn_cmd,
  input  logic [cwsm_pkg::GAIN_W-1:0]          forward_gain,
  input  logic [cwsm_pkg::GAIN_W-1:0]          side_gain,
  input  logic [ANGLE_BITS-1:0]                yaw_angle,
  input  logic [cwsm_pkg::POWER_W-1:0]         power_cap,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]  wheel_a_speed,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]  wheel_b_speed,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]  wheel_c_speed,
  output logic signed [cwsm_pkg::WHEEL_W-1:0]  wheel_d_speed
);
  import cwsm_pkg::*;

  logic push_valid;
  logic push_full;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  cwsm_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_yaw_zero_offset (cfg_yaw_zero_offset),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .mode                (mode),
    .forward_cmd         (forward_cmd),
    .side_cmd            (side_cmd),
    .turn_cmd            (turn_cmd),
    .forward_gain        (forward_gain),
    .side_gain           (side_gain),
    .yaw_angle           (yaw_angle),
    .power_cap           (power_cap),
    .push_valid          (push_valid),
    .push_full           (push_full),
    .push_cmd            (push_cmd)
  );

  cwsm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .full       (push_full),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  cwsm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .wheel_a_speed (wheel_a_speed),
    .wheel_b_speed (wheel_b_speed),
    .wheel_c_speed (wheel_c_speed),
    .wheel_d_speed (wheel_d_speed)
  );

endmodule

>>> tb/wheel_speed_checker.sv
`timescale 1ns / 1ps
module wheel_speed_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [cwsm_pkg::ANGLE_BITS_DEF-1:0]   cfg_yaw_zero_offset,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [1:0]                            mode,
  input  logic signed [cwsm_pkg::CMD_W-1:0]     forward_cmd,
  input  logic signed [cwsm_pkg::CMD_W-1:0]     side_cmd,
  input  logic signed [cwsm_pkg::TURN_W-1:0]    turn_cmd,
  input  logic [cwsm_pkg::GAIN_W-1:0]           forward_gain,
  input  logic [cwsm_pkg::GAIN_W-1:0]           side_gain,
  input  logic [cwsm_pkg::ANGLE_BITS_DEF-1:0]   yaw_angle,
  input  logic [cwsm_pkg::POWER_W-1:0]          power_cap,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_a_speed,
  input  logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_b_speed,
  input  logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_c_speed,
  input  logic signed [cwsm_pkg::WHEEL_W-1:0]   wheel_d_speed,
  output int                                    mismatch_count,
  output int                                    outstanding
);

  localparam int     ANG_W       = cwsm_pkg::ANGLE_BITS_DEF;
  localparam int     WHEEL_W     = cwsm_pkg::WHEEL_W;
  localparam longint WHEEL_MAX   = 8888;
  localparam longint ROT_SCALE   = longint'(1) << 23;
  localparam int     MAX_REPORTS = 32;

  typedef logic [3:0][WHEEL_W-1:0] wheel_set_t;

  int unsigned quarter_wave [0:32] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
    23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
    30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
    32767
  };

  logic [ANG_W-1:0] yaw_offset;
  wheel_set_t       expected_wheels [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    yaw_offset     = '0;
  end

  function automatic longint heading_sine(input logic [ANG_W-1:0] phase);
    logic [1:0]  quad;
    int unsigned frac16;
    int unsigned g;
    int unsigned idx;
    int unsigned lsb;
    longint      mag;
    quad   = phase[ANG_W-1 -: 2];
    frac16 = int'(phase[ANG_W-3:0]) << (18 - ANG_W);
    g      = quad[0] ? 32'd65536 - frac16 : frac16;
    idx    = g >> 11;
    lsb    = g & 32'd2047;
    if (idx >= 32)
      mag = quarter_wave[32];
    else
      mag = quarter_wave[idx] + (((quarter_wave[idx+1] - quarter_wave[idx]) * lsb) >> 11);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic longint spin_rate(input longint watts);
    if (watts < 30)  return 1800;
    if (watts > 300) return 2000;
    if (watts > 100) return 6000;
    return watts * 60;
  endfunction

  function automatic logic [WHEEL_W-1:0] clamp_speed(input longint v);
    if (v > WHEEL_MAX)  return WHEEL_W'(WHEEL_MAX);
    if (v < -WHEEL_MAX) return WHEEL_W'(-WHEEL_MAX);
    return WHEEL_W'(v);
  endfunction

  function automatic wheel_set_t mix_wheels(input logic [1:0] m, input longint fw, sd, tn,
                                            input longint fg, sg,
                                            input logic [ANG_W-1:0] yw,
                                            input longint watts);
    longint           wa, wb, wc, wd;
    longint           s, c, x, y, rs;
    logic [ANG_W-1:0] h;
    wheel_set_t       res;
    wa = 0;
    wb = 0;
    wc = 0;
    wd = 0;
    case (m)
      cwsm_pkg::MODE_FOLLOW: begin
        wa = ((fw + sd + tn) * fg) / 256;
        wb = ((fw - sd + tn) * fg) / 256;
        wc = ((-fw + sd + tn) * fg) / 256;
        wd = ((-fw - sd + tn) * fg) / 256;
      end
      cwsm_pkg::MODE_SPIN, cwsm_pkg::MODE_TRANSLATE: begin
        h  = yw - yaw_offset;
        s  = heading_sine(h);
        c  = heading_sine(h + (ANG_W'(1) << (ANG_W - 2)));
        x  = sd * sg;
        y  = fw * fg;
        rs = (m == cwsm_pkg::MODE_SPIN) ? spin_rate(watts) * ROT_SCALE : 0;
        wa = (rs + x * (c - s) + y * (s + c)) / ROT_SCALE;
        wb = (rs - x * (c + s) + y * (c - s)) / ROT_SCALE;
        wc = (rs + x * (c + s) + y * (s - c)) / ROT_SCALE;
        wd = (rs - x * (c - s) - y * (s + c)) / ROT_SCALE;
      end
      default: ;
    endcase
    res[0] = clamp_speed(wa);
    res[1] = clamp_speed(wb);
    res[2] = clamp_speed(wc);
    res[3] = clamp_speed(wd);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int wheel,
                                 input logic [WHEEL_W-1:0] got_v, want_v);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: wheel %0d %s: got %0d, expected %0d", $time, wheel, what,
               $signed(got_v), $signed(want_v));
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    wheel_set_t got;
    wheel_set_t want;
    if (rst) begin
      yaw_offset = '0;
      expected_wheels.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        yaw_offset = cfg_yaw_zero_offset;
      if (in_valid && !in_stall)
        expected_wheels.push_back(mix_wheels(mode, longint'(forward_cmd), longint'(side_cmd),
                                             longint'(turn_cmd), longint'(forward_gain),
                                             longint'(side_gain), yaw_angle,
                                             longint'(power_cap)));
      if (out_valid && !out_stall) begin
        got = {wheel_d_speed, wheel_c_speed, wheel_b_speed, wheel_a_speed};
        if (expected_wheels.size() == 0) begin
          report_mismatch("result beat with nothing expected", 0, got[0], '0);
        end else begin
          want = expected_wheels.pop_front();
          for (int k = 0; k < 4; k++)
            if (got[k] !== want[k])
              report_mismatch("speed mismatch", k, got[k], want[k]);
        end
      end
    end
    outstanding <= expected_wheels.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cwsm_pkg::*;

  localparam int         ANG_W          = ANGLE_BITS_DEF;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASE_BEATS    = 276;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [ANG_W-1:0]          cfg_yaw_zero_offset;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                mode;
  logic signed [CMD_W-1:0]   forward_cmd;
  logic signed [CMD_W-1:0]   side_cmd;
  logic signed [TURN_W-1:0]  turn_cmd;
  logic [GAIN_W-1:0]         forward_gain;
  logic [GAIN_W-1:0]         side_gain;
  logic [ANG_W-1:0]          yaw_angle;
  logic [POWER_W-1:0]        power_cap;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [WHEEL_W-1:0] wheel_a_speed;
  logic signed [WHEEL_W-1:0] wheel_b_speed;
  logic signed [WHEEL_W-1:0] wheel_c_speed;
  logic signed [WHEEL_W-1:0] wheel_d_speed;
  int                        mismatch_count;
  int                        outstanding;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_pending;
  int          quiet_cycles;

  int unsigned watt_marks [0:7] = '{0, 29, 30, 100, 101, 300, 301, 65535};
  int unsigned yaw_marks  [0:5] = '{0, 1, 2048, 4096, 6144, 8191};

  always #6 clk = ~clk;

  chassis_wheel_speed_mixer_core DUT (.*);

  wheel_speed_checker u_check (.*);

  task automatic offer_command(input logic [1:0] m, input logic signed [CMD_W-1:0] fw, sd,
                               input logic signed [TURN_W-1:0] tn,
                               input logic [GAIN_W-1:0] fg, sg,
                               input logic [ANG_W-1:0] yw, input logic [POWER_W-1:0] pw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    forward_cmd  <= fw;
    side_cmd     <= sd;
    turn_cmd     <= tn;
    forward_gain <= fg;
    side_gain    <= sg;
    yaw_angle    <= yw;
    power_cap    <= pw;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random();
    logic [1:0]               m;
    logic signed [CMD_W-1:0]  fw, sd;
    logic signed [TURN_W-1:0] tn;
    logic [GAIN_W-1:0]        fg, sg;
    logic [ANG_W-1:0]         yw;
    logic [POWER_W-1:0]       pw;
    int unsigned              pick;
    pick = $urandom_range(99);
    if (pick < 5)       m = MODE_UNUSED;
    else if (pick < 38) m = MODE_FOLLOW;
    else if (pick < 72) m = MODE_SPIN;
    else                m = MODE_TRANSLATE;
    case ($urandom_range(7))
      0:       fw = 12'h7FF;
      1:       fw = 12'h800;
      2, 3:    fw = CMD_W'($urandom_range(511)) - CMD_W'(256);
      default: fw = CMD_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       sd = 12'h7FF;
      1:       sd = 12'h800;
      2, 3:    sd = CMD_W'($urandom_range(511)) - CMD_W'(256);
      default: sd = CMD_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       tn = 14'h1FFF;
      1:       tn = 14'h2000;
      2, 3:    tn = TURN_W'($urandom_range(1023)) - TURN_W'(512);
      default: tn = TURN_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       fg = '1;
      1:       fg = '0;
      2, 3, 4: fg = GAIN_W'($urandom_range(128, 384));
      default: fg = GAIN_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       sg = '1;
      1:       sg = '0;
      2, 3, 4: sg = GAIN_W'($urandom_range(128, 384));
      default: sg = GAIN_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       yw = ANG_W'($urandom_range(3)) << (ANG_W - 2);
      1:       yw = (ANG_W'($urandom_range(3)) << (ANG_W - 2)) + ANG_W'($urandom_range(2)) - 1'b1;
      default: yw = ANG_W'($urandom);
    endcase
    case ($urandom_range(7))
      0, 1, 2: pw = POWER_W'($urandom_range(400));
      3:       pw = POWER_W'($urandom_range(27, 32));
      4:       pw = POWER_W'($urandom_range(98, 103));
      5:       pw = POWER_W'($urandom_range(298, 303));
      default: pw = POWER_W'($urandom);
    endcase
    offer_command(m, fw, sd, tn, fg, sg, yw, pw);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_yaw_offset(input logic [ANG_W-1:0] value);
    drain();
    cfg_valid           <= 1'b1;
    cfg_yaw_zero_offset <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst                 = 1'b1;
    cfg_valid           = 1'b0;
    cfg_yaw_zero_offset = '0;
    in_valid            = 1'b0;
    mode                = MODE_FOLLOW;
    forward_cmd         = '0;
    side_cmd            = '0;
    turn_cmd            = '0;
    forward_gain        = '0;
    side_gain           = '0;
    yaw_angle           = '0;
    power_cap           = '0;
    quiet_cycles        = 0;
    hold_pending        = 1'b0;
    send_idle_pct       = 12;
    recv_idle_pct       = 60;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_command(MODE_FOLLOW, 2047, 2047, 8191, 4095, 4095, 0, 0);
    offer_command(MODE_FOLLOW, -2048, -2048, -8192, 4095, 0, 8191, 65535);
    offer_command(MODE_FOLLOW, 100, -50, 30, 256, 256, 0, 0);
    offer_command(MODE_FOLLOW, -1, 0, 0, 1, 0, 0, 0);
    foreach (watt_marks[i])
      offer_command(MODE_SPIN, 0, 0, 0, 256, 256, 0, POWER_W'(watt_marks[i]));
    foreach (yaw_marks[i])
      offer_command(MODE_TRANSLATE, 2047, -2048, 0, 256, 256, ANG_W'(yaw_marks[i]), 0);
    offer_command(MODE_TRANSLATE, 2047, 2047, 0, 4095, 4095, 1024, 0);
    offer_command(MODE_SPIN, -2048, 2047, -1, 4095, 4095, 1024, 65);
    offer_command(MODE_UNUSED, 2047, -2048, 8191, 4095, 4095, 4095, 50);

    load_yaw_offset('1);
    repeat (PHASE_BEATS) offer_random();

    load_yaw_offset(ANG_W'($urandom_range(1, 8190)));
    send_idle_pct = 60;
    recv_idle_pct = 12;
    repeat (PHASE_BEATS) offer_random();

    load_yaw_offset('0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side while commands keep coming, so the block backs up
    hold_pending = 1'b1;
    repeat (PHASE_BEATS) offer_random();

    drain();
    if (mismatch_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/core/cwsm_pkg.sv
rtl/core/cwsm_front.sv
rtl/core/cwsm_queue.sv
rtl/core/cwsm_back.sv
rtl/core/chassis_wheel_speed_mixer_core.sv
tb/wheel_speed_checker.sv
tb/tb_top.sv
